>>> rtl/dsts_pkg.sv
// Shared types, constants and helpers for the DShot transmit scheduler.
// Used by dsts_queue_ctrl, dshot_transmit_scheduler and the testbench; depends on nothing.
package dsts_pkg;

  // Block dimensions
  localparam int PORT_COUNT      = 2;
  localparam int PINS_PER_PORT   = 8;
  localparam int TELEMETRY_DEPTH = 8;
  localparam int FRAME_BITS      = 16;
  localparam int ORDER_DEPTH     = 16;

  // Frame bit positions touched in a telemetry snapshot (0 is the MSB)
  localparam int TLM_BIT  = 11;
  localparam int CRC0_BIT = 15;

  // Derived widths
  localparam int MASK_W  = 8;
  localparam int BIT_W   = $clog2(FRAME_BITS);
  localparam int SH_W    = (TELEMETRY_DEPTH > 1) ? $clog2(TELEMETRY_DEPTH) : 1;
  localparam int SC_W    = $clog2(TELEMETRY_DEPTH + 1);
  localparam int ORD_W   = $clog2(ORDER_DEPTH);
  localparam int OC_W    = $clog2(ORDER_DEPTH + 1);
  localparam int FB_AW   = $clog2(PORT_COUNT * FRAME_BITS);
  localparam int SNAP_WORDS = PORT_COUNT * TELEMETRY_DEPTH * FRAME_BITS;
  localparam int SNAP_AW = $clog2(SNAP_WORDS);

  localparam logic [MASK_W-1:0] PIN_LIMIT = MASK_W'((1 << PINS_PER_PORT) - 1);

  // Input word kinds
  localparam logic KIND_THROTTLE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SPEED_MODE = 2'd0;
  localparam logic [1:0] REG_ATT_PORT0  = 2'd1;
  localparam logic [1:0] REG_ATT_PORT1  = 2'd2;

  // Speed mode codes
  localparam logic [1:0] SPEED_HALF    = 2'd1;
  localparam logic [1:0] SPEED_QUARTER = 2'd2;

  typedef struct packed {
    logic        kind;
    logic        port_select;
    logic [2:0]  pin_index;
    logic [10:0] throttle;
    logic        telemetry_request;
  } in_word_t;

  typedef struct packed {
    logic              is_ack;
    logic              telemetry_queued;
    logic              slot_port;
    logic [3:0]        bit_index;
    logic [MASK_W-1:0] drive_mask;
    logic [MASK_W-1:0] long_pulse_mask;
    logic [2:0]        timing_scale;
    logic              last;
  } out_word_t;

  // Requests into the queue bookkeeping
  typedef struct packed {
    logic thr;
    logic tick;
    logic ok;
    logic want;
    logic port;
  } qc_req_t;

  // Decisions from the queue bookkeeping
  typedef struct packed {
    logic            queued;
    logic [SH_W-1:0] slot;
    logic            use_snap;
    logic            port;
    logic [SH_W-1:0] head;
  } qc_resp_t;

  // 11-bit value, zero telemetry bit, XOR of the three nibbles
  function automatic logic [15:0] build_frame(input logic [10:0] thr);
    logic [11:0] data;
    logic [3:0]  csum;
    data = {thr, 1'b0};
    csum = data[3:0] ^ data[7:4] ^ data[11:8];
    return {data, csum};
  endfunction

endpackage

>>> rtl/dsts_queue_ctrl.sv
// Telemetry snapshot pointers and the shared first-come port order queue.
// Depends on dsts_pkg.
module dsts_queue_ctrl import dsts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qc_req_t  req_i,
  output qc_resp_t resp_o
);

  logic [SH_W-1:0]  snap_head_q [PORT_COUNT];
  logic [SC_W-1:0]  snap_cnt_q  [PORT_COUNT];
  logic             order_q     [ORDER_DEPTH];
  logic [ORD_W-1:0] order_head_q;
  logic [OC_W-1:0]  order_cnt_q;

  logic [SH_W:0]    slot_sum;
  logic             have_order;
  logic             tick_port;

  // Decisions from the current pointers
  always_comb begin
    slot_sum = {1'b0, snap_head_q[req_i.port]} + (SH_W+1)'(snap_cnt_q[req_i.port]);
    if (slot_sum >= (SH_W+1)'(TELEMETRY_DEPTH)) begin
      slot_sum = slot_sum - (SH_W+1)'(TELEMETRY_DEPTH);
    end
    resp_o.slot   = slot_sum[SH_W-1:0];
    resp_o.queued = req_i.ok && req_i.want &&
                    (snap_cnt_q[req_i.port] < SC_W'(TELEMETRY_DEPTH)) &&
                    (order_cnt_q < OC_W'(ORDER_DEPTH));

    have_order      = (order_cnt_q != '0);
    tick_port       = order_q[order_head_q];
    resp_o.port     = tick_port;
    resp_o.use_snap = have_order && (snap_cnt_q[tick_port] != '0);
    resp_o.head     = snap_head_q[tick_port];
  end

  // Pointer updates on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        snap_head_q[p] <= '0;
        snap_cnt_q[p]  <= '0;
      end
      order_head_q <= '0;
      order_cnt_q  <= '0;
    end else if (req_i.thr && resp_o.queued) begin
      snap_cnt_q[req_i.port] <= snap_cnt_q[req_i.port] + SC_W'(1);
      order_q[ORD_W'(order_head_q + order_cnt_q[ORD_W-1:0])] <= req_i.port;
      order_cnt_q <= order_cnt_q + OC_W'(1);
    end else if (req_i.tick && have_order) begin
      order_head_q <= order_head_q + ORD_W'(1);
      order_cnt_q  <= order_cnt_q - OC_W'(1);
      if (resp_o.use_snap) begin
        snap_head_q[tick_port] <= (resp_o.head == SH_W'(TELEMETRY_DEPTH - 1)) ?
                                  '0 : resp_o.head + SH_W'(1);
        snap_cnt_q[tick_port]  <= snap_cnt_q[tick_port] - SC_W'(1);
      end
    end
  end

  // Queue bookkeeping checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    order_cnt_q <= OC_W'(ORDER_DEPTH))
    else $error("order queue count overflow");
  a_queue_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.thr && resp_o.queued |=> order_cnt_q == $past(order_cnt_q) + OC_W'(1))
    else $error("queued request did not grow the order queue");
  a_tick_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.tick && !req_i.thr && have_order |=>
      order_cnt_q == $past(order_cnt_q) - OC_W'(1))
    else $error("tick did not pop the order queue");

endmodule

>>> rtl/dshot_transmit_scheduler.sv
// DShot transmit scheduler top level: frame store, snapshot store, sequencer, output word.
// A set-throttle word does one read-modify-write on the frame store for each of the 16 frame
// bits; its ack is offered once the last write is done, and the next word is accepted once the
// ack is loaded into the output register. A frame tick yields one slot per cycle from the read
// ports of the two stores (32 slots), stalling with the output. Reset clears control state; the
// frame store reads as zero via per-entry valid bits, so no clearing pass is needed.
// Depends on dsts_pkg and dsts_queue_ctrl.
module dshot_transmit_scheduler import dsts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_THR, ST_ACK, ST_TICK} state_e;

  localparam logic [FB_AW-1:0] LAST_IDX = FB_AW'(PORT_COUNT * FRAME_BITS - 1);

  state_e            state_q;
  logic [1:0]        speed_q;
  logic [MASK_W-1:0] att0_q, att1_q;

  // Per-word registers
  logic [15:0]       frame_q;
  logic              thr_port_q, thr_ok_q, thr_queued_q;
  logic [MASK_W-1:0] thr_pm_q;
  logic [SH_W-1:0]   thr_slot_q;
  logic              tick_use_q, tick_port_q;
  logic [SH_W-1:0]   tick_head_q;
  logic [BIT_W-1:0]  bit_q;
  logic [FB_AW-1:0]  idx_q;

  // Read stage
  logic              pend_q, pend_kind_q, pend_vld_q;
  logic [FB_AW-1:0]  pend_addr_q;

  // Stores
  logic [MASK_W-1:0] fb_mem [PORT_COUNT*FRAME_BITS];
  logic [MASK_W-1:0] sn_mem [SNAP_WORDS];
  logic [PORT_COUNT*FRAME_BITS-1:0] fb_vld_q;
  logic [MASK_W-1:0] fb_rd_q, sn_rd_q;

  logic              out_valid_q;
  out_word_t         out_word_q, out_next;

  logic              in_acc, out_free, pend_take, rd_en, sn_re;
  logic              fb_we, sn_we, slot_load, ack_load;
  logic [FB_AW-1:0]  rd_addr;
  logic [SNAP_AW-1:0] sn_raddr, sn_waddr;
  logic [BIT_W-1:0]  pend_bit, rd_bit;
  logic              pend_port;
  logic [MASK_W-1:0] old_bits, new_bits, snap_bits, slot_bits, att;
  logic [2:0]        scale;
  qc_req_t           qc_req;
  qc_resp_t          qc_resp;

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Queue bookkeeping
  assign qc_req.thr  = in_acc && (in_word_i.kind == KIND_THROTTLE);
  assign qc_req.tick = in_acc && (in_word_i.kind == KIND_TICK);
  assign qc_req.ok   = (32'(in_word_i.port_select) < PORT_COUNT) &&
                       (32'(in_word_i.pin_index) < PINS_PER_PORT);
  assign qc_req.want = in_word_i.telemetry_request;
  assign qc_req.port = in_word_i.port_select;

  dsts_queue_ctrl u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qc_req),
    .resp_o (qc_resp)
  );

  // Sequencer reads, read-modify-write data and output selection
  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    pend_take = pend_q && ((pend_kind_q == KIND_THROTTLE) || out_free);
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_q)
      ST_THR: begin
        rd_en   = 1'b1;
        rd_addr = FB_AW'(32'(thr_port_q) * FRAME_BITS + 32'(bit_q));
      end
      ST_TICK: begin
        rd_en   = !pend_q || pend_take;
        rd_addr = idx_q;
      end
      default: ;
    endcase
    sn_re    = rd_en && (state_q == ST_TICK);
    rd_bit   = BIT_W'(idx_q % FRAME_BITS);
    sn_raddr = SNAP_AW'(32'(tick_port_q) * (TELEMETRY_DEPTH * FRAME_BITS) +
                        32'(tick_head_q) * FRAME_BITS + 32'(rd_bit));

    pend_bit  = BIT_W'(pend_addr_q % FRAME_BITS);
    pend_port = 1'(pend_addr_q / FRAME_BITS);
    old_bits  = pend_vld_q ? fb_rd_q : '0;
    new_bits  = frame_q[BIT_W'(FRAME_BITS - 1) - pend_bit] ? (old_bits | thr_pm_q)
                                                            : (old_bits & ~thr_pm_q);
    snap_bits = new_bits;
    if (pend_bit == BIT_W'(TLM_BIT))  snap_bits = snap_bits | thr_pm_q;
    if (pend_bit == BIT_W'(CRC0_BIT)) snap_bits = snap_bits ^ thr_pm_q;
    sn_waddr  = SNAP_AW'(32'(thr_port_q) * (TELEMETRY_DEPTH * FRAME_BITS) +
                         32'(thr_slot_q) * FRAME_BITS + 32'(pend_bit));

    fb_we     = pend_take && (pend_kind_q == KIND_THROTTLE) && thr_ok_q;
    sn_we     = fb_we && thr_queued_q;
    slot_load = pend_take && (pend_kind_q == KIND_TICK);
    ack_load  = (state_q == ST_ACK) && !pend_q && out_free;

    case (speed_q)
      SPEED_HALF:    scale = 3'd2;
      SPEED_QUARTER: scale = 3'd4;
      default:       scale = 3'd1;
    endcase
    att       = (pend_port ? att1_q : att0_q) & PIN_LIMIT;
    slot_bits = (tick_use_q && (pend_port == tick_port_q)) ? sn_rd_q : old_bits;

    out_next = '0;
    out_next.timing_scale = scale;
    if (slot_load) begin
      out_next.slot_port       = pend_port;
      out_next.bit_index       = 4'(pend_bit);
      out_next.drive_mask      = att;
      out_next.long_pulse_mask = slot_bits & att;
      out_next.last            = (pend_addr_q == LAST_IDX);
    end else begin
      out_next.is_ack           = 1'b1;
      out_next.telemetry_queued = thr_queued_q;
      out_next.last             = 1'b1;
    end
  end

  // Frame store and snapshot store
  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[pend_addr_q] <= new_bits;
    if (rd_en) fb_rd_q <= fb_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sn_we) sn_mem[sn_waddr] <= snap_bits;
    if (sn_re) sn_rd_q <= sn_mem[sn_raddr];
  end

  // Frame store valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_vld_q <= '0;
    end else if (fb_we) begin
      fb_vld_q[pend_addr_q] <= 1'b1;
    end
  end

  // Configuration, state machine, read stage and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      speed_q      <= '0;
      att0_q       <= '0;
      att1_q       <= '0;
      frame_q      <= '0;
      thr_port_q   <= 1'b0;
      thr_ok_q     <= 1'b0;
      thr_queued_q <= 1'b0;
      thr_pm_q     <= '0;
      thr_slot_q   <= '0;
      tick_use_q   <= 1'b0;
      tick_port_q  <= 1'b0;
      tick_head_q  <= '0;
      bit_q        <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_kind_q  <= KIND_THROTTLE;
      pend_vld_q   <= 1'b0;
      pend_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SPEED_MODE: speed_q <= cfg_data_i[1:0];
          REG_ATT_PORT0:  att0_q  <= cfg_data_i;
          REG_ATT_PORT1:  att1_q  <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_word_i.kind == KIND_THROTTLE)) begin
            frame_q      <= build_frame(in_word_i.throttle);
            thr_port_q   <= in_word_i.port_select;
            thr_pm_q     <= MASK_W'(1) << in_word_i.pin_index;
            thr_ok_q     <= qc_req.ok;
            thr_queued_q <= qc_resp.queued;
            thr_slot_q   <= qc_resp.slot;
            bit_q        <= '0;
            state_q      <= ST_THR;
          end else if (in_acc) begin
            tick_use_q  <= qc_resp.use_snap;
            tick_port_q <= qc_resp.port;
            tick_head_q <= qc_resp.head;
            idx_q       <= '0;
            state_q     <= ST_TICK;
          end
        end
        ST_THR: begin
          bit_q <= bit_q + BIT_W'(1);
          if (bit_q == BIT_W'(FRAME_BITS - 1)) state_q <= ST_ACK;
        end
        ST_ACK: begin
          if (ack_load) state_q <= ST_IDLE;
        end
        ST_TICK: begin
          if (rd_en) begin
            idx_q <= idx_q + FB_AW'(1);
            if (idx_q == LAST_IDX) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // One read in flight; held until consumed
      if (rd_en) begin
        pend_q      <= 1'b1;
        pend_kind_q <= (state_q == ST_TICK) ? KIND_TICK : KIND_THROTTLE;
        pend_addr_q <= rd_addr;
        pend_vld_q  <= fb_vld_q[rd_addr];
      end else if (pend_take) begin
        pend_q <= 1'b0;
      end

      if (slot_load || ack_load) begin
        out_valid_q <= 1'b1;
        out_word_q  <= out_next;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sequencer checks
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q && !fb_we)
    else $error("word accepted with a read still in flight");
  a_snap_with_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sn_we |-> fb_we && thr_queued_q)
    else $error("snapshot written outside a queued throttle update");
  a_pend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && (pend_kind_q == KIND_TICK) && !out_free |=>
      pend_q && $stable(pend_addr_q) && $stable(fb_rd_q))
    else $error("stalled slot read lost");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_load || ack_load) |-> out_free && !(slot_load && ack_load))
    else $error("output word overwritten");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for dshot_transmit_scheduler: directed table, then random rounds.
// A predictor of the frame store and telemetry queues checks every output word.
// Depends on dsts_pkg and the scheduler RTL.
module testbench;
  import dsts_pkg::*;

  localparam logic [1:0] SPEED_FULL    = 2'd0;
  localparam logic [1:0] SPEED_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIRECTED_ROWS = 26;

  typedef enum logic {ROW_WORD, ROW_REG} row_e;

  // One row of the directed table; typed_tq is used only where typed is set
  typedef struct packed {
    row_e        row;
    logic [1:0]  reg_index;
    logic [7:0]  reg_value;
    logic        kind;
    logic        port;
    logic [2:0]  pin;
    logic [10:0] thr;
    logic        tlm;
    logic        typed;
    logic        typed_tq;
  } step_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_word_t   in_word_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_word_t  out_word_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  // Predictor state
  logic [1:0] speed_reg;
  logic [7:0] attach_reg [PORT_COUNT];
  logic [7:0] pin_masks [PORT_COUNT][FRAME_BITS];
  logic [7:0] tlm_copies [PORT_COUNT][TELEMETRY_DEPTH][FRAME_BITS];
  int         copy_head [PORT_COUNT];
  int         copy_count [PORT_COUNT];
  bit         port_fifo [$];
  out_word_t  awaited_words [$];

  int items_sent;
  int error_count;
  int idle_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  bit cfg_open;
  bit hold_off_req;

  // Columns: row, reg index, reg value, kind, port, pin, throttle, telemetry, typed, typed ack
  step_t directed [DIRECTED_ROWS] = '{
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd0, 11'd0,    1'b0, 1'b1, 1'b0},
    '{ROW_REG,  REG_ATT_PORT0,  8'hFF, KIND_THROTTLE, 1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_REG,  REG_ATT_PORT1,  8'hA5, KIND_THROTTLE, 1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_REG,  REG_SPEED_MODE, 8'(SPEED_QUARTER), KIND_THROTTLE, 1'b0, 3'd0, 11'd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd0, 11'd2047, 1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b1, 3'd7, 11'h555,  1'b0, 1'b1, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b1, 3'd3, 11'h2AA,  1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b1, 3'd7, 11'd2047, 1'b1, 1'b0, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_REG,  REG_SPEED_MODE, 8'(SPEED_UNKNOWN), KIND_THROTTLE, 1'b0, 3'd0, 11'd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_REG,  REG_ATT_PORT1,  8'h00, KIND_THROTTLE, 1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b1, 3'd5, 11'd48,   1'b0, 1'b1, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0},
    '{ROW_REG,  REG_SPEED_MODE, 8'(SPEED_HALF), KIND_THROTTLE, 1'b0, 3'd0, 11'd0,
      1'b0, 1'b0, 1'b0},
    // port 0 telemetry queue filled to the brim, the ninth request is refused
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd0, 11'd1,    1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd1, 11'd2,    1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd2, 11'd4,    1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd3, 11'd8,    1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd4, 11'd16,   1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd5, 11'd32,   1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd6, 11'd64,   1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd7, 11'd128,  1'b1, 1'b1, 1'b1},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_THROTTLE, 1'b0, 3'd0, 11'd1024, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_SPEED_MODE, 8'h00, KIND_TICK,     1'b0, 3'd0, 11'd0,    1'b0, 1'b0, 1'b0}
  };

  dshot_transmit_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Predict the words caused by one accepted input word
  task automatic predict_dshot_words(input in_word_t w, input bit use_typed,
                                     input bit typed_tq);
    logic [7:0]  send_masks [PORT_COUNT][FRAME_BITS];
    logic [15:0] frame;
    logic [3:0]  csum;
    logic [7:0]  pm;
    logic [7:0]  att;
    out_word_t   o;
    bit          queued;
    bit          q;
    int          slot;
    int          p;
    int          i;
    o = '0;
    o.timing_scale = (speed_reg == SPEED_HALF) ? 3'd2 :
                     (speed_reg == SPEED_QUARTER) ? 3'd4 : 3'd1;
    if (w.kind == KIND_THROTTLE) begin
      queued = 1'b0;
      if (w.port_select < PORT_COUNT && w.pin_index < PINS_PER_PORT) begin
        pm = 8'd1 << w.pin_index;
        csum = w.throttle[10:7] ^ w.throttle[6:3] ^ {w.throttle[2:0], 1'b0};
        frame = {w.throttle, 1'b0, csum};
        for (i = 0; i < FRAME_BITS; i++) begin
          if (frame[FRAME_BITS-1-i]) pin_masks[w.port_select][i] |= pm;
          else pin_masks[w.port_select][i] &= ~pm;
        end
        if (w.telemetry_request && copy_count[w.port_select] < TELEMETRY_DEPTH &&
            port_fifo.size() < ORDER_DEPTH) begin
          slot = (copy_head[w.port_select] + copy_count[w.port_select]) % TELEMETRY_DEPTH;
          for (i = 0; i < FRAME_BITS; i++)
            tlm_copies[w.port_select][slot][i] = pin_masks[w.port_select][i];
          tlm_copies[w.port_select][slot][TLM_BIT] |= pm;
          tlm_copies[w.port_select][slot][CRC0_BIT] ^= pm;
          copy_count[w.port_select]++;
          port_fifo.push_back(w.port_select);
          queued = 1'b1;
        end
      end
      o.is_ack = 1'b1;
      o.telemetry_queued = use_typed ? typed_tq : queued;
      o.last = 1'b1;
      awaited_words.push_back(o);
    end else begin
      send_masks = pin_masks;
      // oldest telemetry copy, if any, stands in for its port's frames
      if (port_fifo.size() != 0) begin
        q = port_fifo.pop_front();
        if (copy_count[q] != 0) begin
          for (i = 0; i < FRAME_BITS; i++)
            send_masks[q][i] = tlm_copies[q][copy_head[q]][i];
          copy_head[q] = (copy_head[q] + 1) % TELEMETRY_DEPTH;
          copy_count[q]--;
        end
      end
      for (p = 0; p < PORT_COUNT; p++) begin
        att = attach_reg[p] & PIN_LIMIT;
        for (i = 0; i < FRAME_BITS; i++) begin
          o.slot_port = 1'(p);
          o.bit_index = 4'(i);
          o.drive_mask = att;
          o.long_pulse_mask = send_masks[p][i] & att;
          o.last = (p == PORT_COUNT - 1 && i == FRAME_BITS - 1);
          awaited_words.push_back(o);
        end
      end
    end
  endtask

  // Drop valid and wait until every awaited word has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
  endtask

  // Register write; valid is left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    if (!cfg_open) wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SPEED_MODE: speed_reg = val[1:0];
      REG_ATT_PORT0:  attach_reg[0] = val;
      REG_ATT_PORT1:  attach_reg[1] = val;
      default: ;
    endcase
    cfg_open = 1'b1;
  endtask

  // Offer one input word, with random gaps before it
  task automatic send_word(input in_word_t w, input bit use_typed, input bit typed_tq);
    if (cfg_open) begin
      cfg_valid_i <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_dshot_words(w, use_typed, typed_tq);
    items_sent++;
  endtask

  function automatic in_word_t random_throttle(input bit tlm);
    in_word_t w;
    w.kind = KIND_THROTTLE;
    w.port_select = 1'($urandom_range(1));
    w.pin_index = 3'($urandom_range(7));
    w.throttle = 11'($urandom_range(2047));
    w.telemetry_request = tlm;
    return w;
  endfunction

  // Mostly frame rounds (a few throttles, then a tick), some telemetry bursts, some noise
  task automatic run_random(input int target);
    in_word_t w;
    int       stop;
    int       r;
    int       n;
    int       k;
    stop = items_sent + target;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 60) begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) send_word(random_throttle($urandom_range(3) == 0), 1'b0, 1'b0);
        w = random_throttle(1'($urandom_range(1)));
        w.kind = KIND_TICK;
        send_word(w, 1'b0, 1'b0);
      end else if (r < 75) begin
        n = $urandom_range(18, 6);
        for (k = 0; k < n; k++) send_word(random_throttle(1'b1), 1'b0, 1'b0);
        n = $urandom_range(3, 1);
        for (k = 0; k < n; k++) begin
          w = random_throttle(1'($urandom_range(1)));
          w.kind = KIND_TICK;
          send_word(w, 1'b0, 1'b0);
        end
      end else begin
        w = random_throttle(1'($urandom_range(1)));
        w.kind = 1'($urandom_range(1));
        send_word(w, 1'b0, 1'b0);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin : rx_ready
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output checker against the oldest awaited word
  always @(posedge clk_i) begin : out_check
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_word_o;
      if (awaited_words.size() == 0) begin
        $error("unexpected output word %h", got);
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        if (got.is_ack !== want.is_ack) begin
          $error("is_ack: expected %0h, got %0h", want.is_ack, got.is_ack);
          error_count++;
        end
        if (got.telemetry_queued !== want.telemetry_queued) begin
          $error("telemetry_queued: expected %0h, got %0h",
                 want.telemetry_queued, got.telemetry_queued);
          error_count++;
        end
        if (got.slot_port !== want.slot_port) begin
          $error("slot_port: expected %0h, got %0h", want.slot_port, got.slot_port);
          error_count++;
        end
        if (got.bit_index !== want.bit_index) begin
          $error("bit_index: expected %0d, got %0d", want.bit_index, got.bit_index);
          error_count++;
        end
        if (got.drive_mask !== want.drive_mask) begin
          $error("drive_mask: expected %0h, got %0h", want.drive_mask, got.drive_mask);
          error_count++;
        end
        if (got.long_pulse_mask !== want.long_pulse_mask) begin
          $error("long_pulse_mask: expected %0h, got %0h",
                 want.long_pulse_mask, got.long_pulse_mask);
          error_count++;
        end
        if (got.timing_scale !== want.timing_scale) begin
          $error("timing_scale: expected %0d, got %0d", want.timing_scale, got.timing_scale);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0h, got %0h", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word accepted on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin : stimulus
    in_word_t w;
    int       k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_SPEED_MODE;
    cfg_data_i   = '0;
    items_sent   = 0;
    cfg_open     = 1'b0;
    hold_off_req = 1'b0;
    tx_idle_pct  = 8;
    rx_idle_pct  = 45;
    speed_reg    = SPEED_FULL;
    foreach (attach_reg[p]) begin
      attach_reg[p] = '0;
      copy_head[p]  = 0;
      copy_count[p] = 0;
    end
    foreach (pin_masks[p, i]) pin_masks[p][i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed[k].row == ROW_REG) begin
        write_reg(directed[k].reg_index, directed[k].reg_value);
      end else begin
        w.kind = directed[k].kind;
        w.port_select = directed[k].port;
        w.pin_index = directed[k].pin;
        w.throttle = directed[k].thr;
        w.telemetry_request = directed[k].tlm;
        send_word(w, directed[k].typed, directed[k].typed_tq);
      end
    end

    // sender mostly busy, receiver stalls often
    write_reg(REG_SPEED_MODE, 8'(SPEED_FULL));
    write_reg(REG_ATT_PORT0, 8'($urandom_range(255)));
    write_reg(REG_ATT_PORT1, 8'hFF);
    run_random(64);

    // the other way round
    tx_idle_pct = 45;
    rx_idle_pct = 8;
    write_reg(REG_SPEED_MODE, 8'($urandom_range(3)));
    write_reg(REG_ATT_PORT0, 8'h00);
    write_reg(REG_ATT_PORT1, 8'($urandom_range(255)));
    run_random(64);

    // no idling, with one long receiver hold-off to back the block up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_SPEED_MODE, 8'(SPEED_QUARTER));
    write_reg(REG_ATT_PORT0, 8'($urandom_range(255)));
    write_reg(REG_ATT_PORT1, 8'($urandom_range(255)));
    hold_off_req = 1'b1;
    run_random(64);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
